>>> design/gasp_pkg.sv
// Package for the grid A* path search block: sizes, costs, move tables and codes.
// Depends on nothing; every other design file imports it.
package gasp_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int IDX_W       = COL_W + ROW_W;
    localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;
    localparam int DIM_W       = 7;
    localparam int COST_W      = 21;
    localparam int POS_W       = 6;

    localparam logic [COST_W-1:0] COST_LIMIT    = 21'h1FFFFF;
    localparam logic [COST_W-1:0] STEP_STRAIGHT = 21'd256;
    localparam logic [COST_W-1:0] STEP_DIAGONAL = 21'd362;

    // Input kinds.
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_STEP   = 2'd2;

    // Register indexes.
    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             blocked;
        logic [POS_W-1:0] goal_x;
        logic [POS_W-1:0] goal_y;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [COST_W-1:0] path_cost;
        logic [POS_W-1:0]  step_x;
        logic [POS_W-1:0]  step_y;
        logic              last;
    } t_out_item;

    // Request to and answer from the shared square-root unit.
    typedef struct packed {
        logic        start;
        logic [31:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic        done;
        logic [15:0] root;
    } t_sqrt_rsp;

    // Move offsets, encoded as +1 / 0 / -1.
    function automatic logic [1:0] move_dx(input logic [2:0] d);
        unique case (d)
            3'd0, 3'd6, 3'd7: move_dx = 2'b01;
            3'd2, 3'd4, 3'd5: move_dx = 2'b11;
            default:          move_dx = 2'b00;
        endcase
    endfunction

    function automatic logic [1:0] move_dy(input logic [2:0] d);
        unique case (d)
            3'd1, 3'd5, 3'd7: move_dy = 2'b01;
            3'd3, 3'd4, 3'd6: move_dy = 2'b11;
            default:          move_dy = 2'b00;
        endcase
    endfunction

endpackage

>>> design/gasp_stream_if.sv
// Valid/ready stream interface carrying one payload struct.
// Depends on gasp_pkg for the payload types.
interface gasp_in_if (input logic i_clk);
    import gasp_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gasp_out_if (input logic i_clk);
    import gasp_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/gasp_sqrt.sv
// Bit-serial integer square root with round to nearest, one result bit per cycle.
// Depends on gasp_pkg for the request and answer structs.
module gasp_sqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gasp_pkg::t_sqrt_req  i_req,
    output gasp_pkg::t_sqrt_rsp  o_rsp
);
    import gasp_pkg::*;

    logic [33:0] r_rem;
    logic [31:0] r_num;
    logic [15:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] n_rem;
    logic [33:0] n_trial;
    logic [16:0] n_rnd;

    // One restoring step: bring down two radicand bits and try root*4+1.
    always_comb begin
        n_rem   = {r_rem[31:0], r_num[31:30]};
        n_trial = {16'd0, r_root, 2'b01};
        n_rnd   = {1'b0, r_root} + 17'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_rem  <= '0;
                r_root <= '0;
                r_num  <= i_req.radicand;
            end else if (r_busy) begin
                if (r_cnt == 5'd16) begin
                    // Remainder above root means the nearest integer is root+1.
                    if (r_rem > {18'd0, r_root}) r_root <= n_rnd[15:0];
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_num <= {r_num[29:0], 2'b00};
                    r_cnt <= r_cnt + 5'd1;
                    if (n_rem >= n_trial) begin
                        r_rem  <= n_rem - n_trial;
                        r_root <= {r_root[14:0], 1'b1};
                    end else begin
                        r_rem  <= n_rem;
                        r_root <= {r_root[14:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("sqrt done held");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy)) else $error("sqrt done without work");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= 5'd16) else $error("sqrt count overrun");
`endif
endmodule

>>> design/grid_astar_path_search_top.sv
// Top level of the grid A* path search: cell stores, sequencer and result register.
// Depends on gasp_pkg, the stream interfaces and gasp_sqrt.
//
//  channel  | dir | handshake          | payload
//  in_ch    | in  | valid/ready        | kind, pos_x, pos_y, blocked, goal_x, goal_y
//  out_ch   | out | valid/ready        | found, path_cost, step_x, step_y, last
//  cfg      | in  | i_cfg_we           | i_cfg_index (1 bit), i_cfg_data (7 bits)
//
// A search first clears the flag stores (one cell a cycle), then per expansion
// scans every cell of the grid through the single store read port and checks each
// neighbor, using the shared square-root unit for a newly opened one; the scan
// dominates the worst case. After reset a pass over every cell clears the
// occupancy store; no transaction is accepted meanwhile. The block takes no new
// item until the result waits in the output register and is taken.
module grid_astar_path_search_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    gasp_in_if.sink                     in_ch,
    gasp_out_if.source                  out_ch,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_index,
    input  logic [gasp_pkg::DIM_W-1:0]  i_cfg_data
);
    import gasp_pkg::*;

    localparam logic [4:0] S_CLR_MAP = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_CLR     = 5'd2;
    localparam logic [4:0] S_SEED    = 5'd3;
    localparam logic [4:0] S_HWAIT   = 5'd4;
    localparam logic [4:0] S_SCAN_RD = 5'd5;
    localparam logic [4:0] S_SCAN_EV = 5'd6;
    localparam logic [4:0] S_PICK    = 5'd7;
    localparam logic [4:0] S_NB_RD   = 5'd8;
    localparam logic [4:0] S_NB_EV   = 5'd9;
    localparam logic [4:0] S_NB_H    = 5'd10;
    localparam logic [4:0] S_OUT     = 5'd11;
    localparam logic [4:0] S_TR_RD   = 5'd12;
    localparam logic [4:0] S_TR_EV   = 5'd13;
    localparam logic [4:0] S_SEED_RD = 5'd14;

    // Cell stores: one entry per cell, {occupied} and {open, closed, g, h, dir}.
    logic                r_occ   [CELL_COUNT];
    logic                r_open  [CELL_COUNT];
    logic                r_clsd  [CELL_COUNT];
    logic [COST_W-1:0]   r_gst   [CELL_COUNT];
    logic [COST_W-1:0]   r_hst   [CELL_COUNT];
    logic [2:0]          r_dir   [CELL_COUNT];

    logic [4:0]          r_state;
    logic [IDX_W:0]      r_cnt;
    logic [DIM_W-1:0]    r_w_reg, r_h_reg;
    logic [COL_W:0]      r_w;
    logic [ROW_W:0]      r_h;
    logic [POS_W-1:0]    r_gx, r_gy;
    logic [IDX_W-1:0]    r_start;
    logic [IDX_W-1:0]    r_cursor;
    logic                r_tdone;
    logic [IDX_W-1:0]    r_addr;
    logic                r_rd_occ, r_rd_open, r_rd_clsd;
    logic [COST_W-1:0]   r_rd_g, r_rd_h;
    logic [2:0]          r_rd_dir;
    logic [COL_W-1:0]    r_sx;
    logic [ROW_W-1:0]    r_sy;
    logic                r_any;
    logic [COST_W:0]     r_bestf;
    logic [IDX_W-1:0]    r_best;
    logic [COST_W-1:0]   r_bg;
    logic [2:0]          r_d;
    logic [COST_W-1:0]   r_ng;
    logic                r_nb_new;
    logic                r_seed;
    logic                r_ov;
    t_out_item           r_out;
    t_sqrt_req           n_sq;
    t_sqrt_rsp           sq_rsp;

    logic                w_en;
    logic [IDX_W-1:0]    w_addr;
    logic                w_open, w_clsd, w_wr_cost, w_wr_h;
    logic [COST_W-1:0]   w_g, w_h;
    logic [2:0]          w_dir;

    logic                in_fire;
    logic [COL_W-1:0]    bx;
    logic [ROW_W-1:0]    by;
    logic [1:0]          mdx, mdy, tdx, tdy;
    logic [COL_W+1:0]    nx;
    logic [ROW_W+1:0]    ny;
    logic                nb_in;
    logic [COST_W:0]     f_sum;
    logic [COST_W:0]     ng_sum;
    logic [POS_W:0]      hdx, hdy;
    logic [COL_W-1:0]    hx;
    logic [ROW_W-1:0]    hy;
    logic [13:0]         hsq;
    logic [COL_W+1:0]    tx;
    logic [ROW_W+1:0]    ty;

    gasp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_sq),
        .o_rsp   (sq_rsp)
    );

    assign in_fire      = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (r_state == S_IDLE) && !r_ov;
    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_out;

    // Dimensions clamped to 1..MAX.
    always_comb begin
        r_w = (r_w_reg == '0) ? (COL_W+1)'(1)
            : (r_w_reg > DIM_W'(MAX_COLUMNS)) ? (COL_W+1)'(MAX_COLUMNS) : r_w_reg[COL_W:0];
        r_h = (r_h_reg == '0) ? (ROW_W+1)'(1)
            : (r_h_reg > DIM_W'(MAX_ROWS)) ? (ROW_W+1)'(MAX_ROWS) : r_h_reg[ROW_W:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_reg <= DIM_W'(MAX_COLUMNS);
            r_h_reg <= DIM_W'(MAX_ROWS);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_WIDTH) r_w_reg <= i_cfg_data;
            else                          r_h_reg <= i_cfg_data;
        end
    end

    // Geometry of the best cell, its neighbor, the trace predecessor, the cost sums and the heuristic operand.
    always_comb begin
        mdx    = move_dx(r_d);
        mdy    = move_dy(r_d);
        tdx    = move_dx(r_rd_dir);
        tdy    = move_dy(r_rd_dir);
        bx     = r_best[COL_W-1:0];
        by     = r_best[IDX_W-1:COL_W];
        nx     = {2'b00, bx} + {{COL_W{mdx[1]}}, mdx};
        ny     = {2'b00, by} + {{ROW_W{mdy[1]}}, mdy};
        nb_in  = !nx[COL_W+1] && !ny[ROW_W+1]
               && (nx[COL_W:0] < r_w) && (ny[ROW_W:0] < r_h);
        ng_sum = {1'b0, r_bg} + {1'b0, (r_d[2] ? STEP_DIAGONAL : STEP_STRAIGHT)};
        f_sum  = {1'b0, r_rd_g} + {1'b0, r_rd_h};
        hx     = r_seed ? r_sx : nx[COL_W-1:0];
        hy     = r_seed ? r_sy : ny[ROW_W-1:0];
        hdx    = ({1'b0, POS_W'(hx)} > {1'b0, r_gx}) ? {1'b0, POS_W'(hx)} - {1'b0, r_gx}
                                                     : {1'b0, r_gx} - {1'b0, POS_W'(hx)};
        hdy    = ({1'b0, POS_W'(hy)} > {1'b0, r_gy}) ? {1'b0, POS_W'(hy)} - {1'b0, r_gy}
                                                     : {1'b0, r_gy} - {1'b0, POS_W'(hy)};
        hsq    = {2'b00, ({6'd0, hdx[POS_W-1:0]} * {6'd0, hdx[POS_W-1:0]})}
               + {2'b00, ({6'd0, hdy[POS_W-1:0]} * {6'd0, hdy[POS_W-1:0]})};
        tx     = {2'b00, r_cursor[COL_W-1:0]} - {{COL_W{tdx[1]}}, tdx};
        ty     = {2'b00, r_cursor[IDX_W-1:COL_W]} - {{ROW_W{tdy[1]}}, tdy};
    end

    // Store read port, registered.
    always_ff @(posedge i_clk) begin
        r_rd_occ  <= r_occ[r_addr];
        r_rd_open <= r_open[r_addr];
        r_rd_clsd <= r_clsd[r_addr];
        r_rd_g    <= r_gst[r_addr];
        r_rd_h    <= r_hst[r_addr];
        r_rd_dir  <= r_dir[r_addr];
    end

    // Store write port.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_open[w_addr] <= w_open;
            r_clsd[w_addr] <= w_clsd;
            if (w_wr_cost) begin
                r_gst[w_addr] <= w_g;
                r_dir[w_addr] <= w_dir;
            end
            if (w_wr_h) r_hst[w_addr] <= w_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR_MAP) r_occ[r_cnt[IDX_W-1:0]] <= 1'b0;
        else if (in_fire && in_ch.data.kind == KIND_LOAD)
            r_occ[{in_ch.data.pos_y[ROW_W-1:0], in_ch.data.pos_x[COL_W-1:0]}]
                <= in_ch.data.blocked;
    end

    // Write port and square-root request control.
    always_comb begin
        w_en = 1'b0; w_addr = r_addr; w_open = 1'b0; w_clsd = 1'b0;
        w_wr_cost = 1'b0; w_wr_h = 1'b0; w_g = r_ng; w_h = {5'd0, sq_rsp.root};
        w_dir = r_d; n_sq.start = 1'b0; n_sq.radicand = {2'b00, hsq, 16'd0};
        unique case (r_state)
            S_CLR: begin
                w_en = 1'b1; w_addr = r_cnt[IDX_W-1:0];
            end
            S_SEED: begin
                n_sq.start = 1'b1;
            end
            S_HWAIT: begin
                if (sq_rsp.done) begin
                    w_en = 1'b1; w_open = 1'b1; w_wr_h = 1'b1; w_wr_cost = 1'b1;
                    w_g = r_seed ? '0 : r_ng;
                end
            end
            S_PICK: begin
                w_en = !(bx == r_gx[COL_W-1:0] && by == r_gy[ROW_W-1:0]) && r_any;
                w_addr = r_best; w_clsd = 1'b1;
            end
            S_NB_EV: begin
                if (nb_in && !r_rd_occ && !r_rd_clsd && r_rd_open && r_rd_g > r_ng) begin
                    w_en = 1'b1; w_open = 1'b1; w_wr_cost = 1'b1;
                end
            end
            S_NB_H: begin
                n_sq.start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR_MAP;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_start <= '0;
            r_cursor <= '0;
            r_tdone <= 1'b1;
        end else begin
            if (out_ch.valid && out_ch.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_CLR_MAP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (IDX_W+1)'(CELL_COUNT - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_out <= '0;
                        r_gx  <= in_ch.data.goal_x;
                        r_gy  <= in_ch.data.goal_y;
                        r_sx  <= in_ch.data.pos_x[COL_W-1:0];
                        r_sy  <= in_ch.data.pos_y[ROW_W-1:0];
                        unique case (in_ch.data.kind)
                            KIND_SEARCH: begin
                                r_tdone <= 1'b1;
                                if ({1'b0, in_ch.data.pos_x} >= (POS_W+1)'(r_w)
                                    || {1'b0, in_ch.data.pos_y} >= (POS_W+1)'(r_h)) begin
                                    r_ov <= 1'b1;
                                end else begin
                                    r_cnt   <= '0;
                                    r_state <= S_CLR;
                                end
                            end
                            KIND_STEP: begin
                                if (!r_tdone) begin
                                    r_addr  <= r_cursor;
                                    r_state <= S_TR_RD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (IDX_W+1)'(CELL_COUNT - 1)) begin
                        r_addr  <= {r_sy, r_sx};
                        r_start <= {r_sy, r_sx};
                        r_seed  <= 1'b1;
                        r_state <= S_SEED_RD;
                    end
                end
                S_SEED_RD: r_state <= S_SEED;
                S_SEED:    r_state <= S_HWAIT;
                S_HWAIT: begin
                    if (sq_rsp.done) begin
                        if (r_seed) begin
                            r_seed  <= 1'b0;
                            r_cnt   <= '0;
                            r_any   <= 1'b0;
                            r_addr  <= '0;
                            r_state <= S_SCAN_RD;
                        end else begin
                            r_state <= S_OUT;
                            if (r_d == 3'd7) begin
                                r_cnt <= '0; r_any <= 1'b0; r_addr <= '0;
                                r_state <= S_SCAN_RD;
                            end
                            r_d <= r_d + 3'd1;
                        end
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_EV;
                S_SCAN_EV: begin
                    // Keep the last open cell with the least f.
                    if (r_rd_open && (r_addr[COL_W-1:0] < r_w[COL_W-1:0] || r_w[COL_W])
                        && (!r_any || f_sum <= r_bestf)) begin
                        r_any   <= 1'b1;
                        r_bestf <= f_sum;
                        r_best  <= r_addr;
                        r_bg    <= r_rd_g;
                    end
                    if (r_addr == {ROW_W'(r_h - 1'b1), COL_W'(r_w - 1'b1)}) begin
                        r_state <= S_PICK;
                    end else begin
                        if ({1'b0, r_addr[COL_W-1:0]} == r_w - 1'b1)
                            r_addr <= {r_addr[IDX_W-1:COL_W] + 1'b1, COL_W'(0)};
                        else
                            r_addr <= r_addr + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_PICK: begin
                    if (!r_any) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (bx == r_gx[COL_W-1:0] && by == r_gy[ROW_W-1:0]) begin
                        r_out.found     <= 1'b1;
                        r_out.path_cost <= r_bg;
                        r_cursor        <= r_best;
                        r_tdone         <= 1'b0;
                        r_ov            <= 1'b1;
                        r_state         <= S_IDLE;
                    end else begin
                        r_d     <= 3'd0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // Address the neighbor in direction r_d.
                    r_addr  <= {ny[ROW_W-1:0], nx[COL_W-1:0]};
                    r_ng    <= ng_sum[COST_W] ? COST_LIMIT : ng_sum[COST_W-1:0];
                    r_state <= S_NB_RD;
                end
                S_NB_RD: begin
                    r_addr  <= {ny[ROW_W-1:0], nx[COL_W-1:0]};
                    r_ng    <= ng_sum[COST_W] ? COST_LIMIT : ng_sum[COST_W-1:0];
                    r_state <= S_NB_EV;
                end
                S_NB_EV: begin
                    if (nb_in && !r_rd_occ && !r_rd_clsd && !r_rd_open) begin
                        r_state <= S_NB_H;
                    end else if (r_d == 3'd7) begin
                        r_cnt <= '0; r_any <= 1'b0; r_addr <= '0;
                        r_state <= S_SCAN_RD;
                    end else begin
                        r_d     <= r_d + 3'd1;
                        r_state <= S_OUT;
                    end
                end
                S_NB_H: r_state <= S_HWAIT;
                S_TR_RD: r_state <= S_TR_EV;
                S_TR_EV: begin
                    r_out.step_x <= POS_W'(r_cursor[COL_W-1:0]);
                    r_out.step_y <= POS_W'(r_cursor[IDX_W-1:COL_W]);
                    r_out.last   <= (r_cursor == r_start);
                    r_ov         <= 1'b1;
                    r_state      <= S_IDLE;
                    if (r_cursor == r_start || tx[COL_W+1] || ty[ROW_W+1]
                        || tx[COL_W] || ty[ROW_W])
                        r_tdone <= 1'b1;
                    else
                        r_cursor <= {ty[ROW_W-1:0], tx[COL_W-1:0]};
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !out_ch.ready) |=> r_ov && $stable(r_out)) else $error("result lost");
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(r_out.found && r_out.last)) else $error("mixed result");
    a_trace_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TR_EV && r_cursor == r_start) |=> r_tdone)
        else $error("trace not ended at start");
`endif
endmodule

>>> verif/tb_grid_astar_path_search_top.sv
// Testbench for the grid A* path search top: drives load, search and step transactions
// and checks every result against an A* predictor kept inside the bench.
// Depends on gasp_pkg, the gasp stream interfaces and grid_astar_path_search_top.
module tb_grid_astar_path_search_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gasp_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [0:0]           i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;

    gasp_in_if  in_ch (i_clk);
    gasp_out_if out_ch (i_clk);

    grid_astar_path_search_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Move tables, in the order that the parent direction codes use.
    const int step_dx[8] = '{1, 0, -1, 0, -1, -1, 1, 1};
    const int step_dy[8] = '{0, 1, 0, -1, -1, 1, -1, 1};

    // Predictor state; every cell starts free with zero cost.
    bit          cell_blocked [CELL_COUNT];
    bit          cell_open    [CELL_COUNT];
    bit          cell_closed  [CELL_COUNT];
    int unsigned cell_g       [CELL_COUNT];
    int unsigned cell_h       [CELL_COUNT];
    bit [2:0]    cell_parent  [CELL_COUNT];
    int unsigned path_start = 0;
    int unsigned path_cursor = 0;
    bit          path_ended = 1'b1;
    int unsigned grid_cols = 64;
    int unsigned grid_rows = 64;

    t_in_item  items_to_send [$];
    t_out_item results_due [$];
    int        error_count = 0;
    int        send_gap;
    int        take_gap;
    bit        no_idling;

    always #2 i_clk = ~i_clk;

    // Queue helpers for pending transactions and expected results.
    function automatic void add_item(input t_in_item it);
        items_to_send.insert(items_to_send.size(), it);
    endfunction

    function automatic void add_expected(input t_out_item r);
        results_due.insert(results_due.size(), r);
    endfunction

    function automatic int unsigned fit_dim(input int unsigned v, input int unsigned maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Euclidean distance to the goal, 8 fraction bits, rounded to nearest.
    function automatic int unsigned goal_distance(input int x, input int y,
                                                  input int gx, input int gy);
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned n;
        longint unsigned s;
        dx = (x > gx) ? x - gx : gx - x;
        dy = (y > gy) ? y - gy : gy - y;
        n = (dx * dx + dy * dy) * 65536;
        s = root_floor(n);
        if (n - s * s > s) s++;
        return s;
    endfunction

    // Full A* run; returns 1 when the goal is reached and sets the trace.
    function automatic bit astar_search(input int sx, input int sy, input int gx, input int gy,
                                        output int unsigned cost);
        int unsigned w;
        int unsigned h;
        int unsigned s;
        int unsigned best;
        int unsigned bestf;
        int unsigned f;
        int unsigned g;
        int unsigned ng;
        int unsigned ni;
        int cx;
        int cy;
        int nx;
        int ny;
        bit any;
        w = fit_dim(grid_cols, MAX_COLUMNS);
        h = fit_dim(grid_rows, MAX_ROWS);
        cost = 0;
        path_ended = 1;
        if (sx >= w || sy >= h) return 0;
        for (int i = 0; i < CELL_COUNT; i++) begin
            cell_open[i] = 0;
            cell_closed[i] = 0;
        end
        s = sy * MAX_COLUMNS + sx;
        path_start = s;
        cell_open[s] = 1;
        cell_g[s] = 0;
        cell_h[s] = goal_distance(sx, sy, gx, gy);
        forever begin
            any = 0;
            best = 0;
            bestf = 0;
            // Pick the open cell of least f; ties go to the greatest index.
            for (int y = 0; y < h; y++) begin
                for (int x = 0; x < w; x++) begin
                    if (cell_open[y * MAX_COLUMNS + x]) begin
                        f = cell_g[y * MAX_COLUMNS + x] + cell_h[y * MAX_COLUMNS + x];
                        if (!any || f <= bestf) begin
                            any = 1;
                            bestf = f;
                            best = y * MAX_COLUMNS + x;
                        end
                    end
                end
            end
            if (!any) return 0;
            cx = best % MAX_COLUMNS;
            cy = best / MAX_COLUMNS;
            g = cell_g[best];
            if (cx == gx && cy == gy) begin
                cost = g;
                path_cursor = best;
                path_ended = 0;
                return 1;
            end
            cell_open[best] = 0;
            cell_closed[best] = 1;
            // Relax the eight neighbors.
            for (int d = 0; d < 8; d++) begin
                nx = cx + step_dx[d];
                ny = cy + step_dy[d];
                if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                ni = ny * MAX_COLUMNS + nx;
                if (cell_blocked[ni] || cell_closed[ni]) continue;
                ng = g + ((d < 4) ? STEP_STRAIGHT : STEP_DIAGONAL);
                if (ng > COST_LIMIT) ng = COST_LIMIT;
                if (!cell_open[ni]) begin
                    cell_open[ni] = 1;
                    cell_g[ni] = ng;
                    cell_parent[ni] = d[2:0];
                    cell_h[ni] = goal_distance(nx, ny, gx, gy);
                end else if (cell_g[ni] > ng) begin
                    cell_g[ni] = ng;
                    cell_parent[ni] = d[2:0];
                end
            end
        end
    endfunction

    // Apply one accepted transaction to the predictor and queue its result, if any.
    function automatic void plan_item(input t_in_item it);
        t_out_item r;
        int unsigned cost;
        int unsigned idx;
        int x;
        int y;
        int px;
        int py;
        r = '0;
        case (it.kind)
            KIND_LOAD: begin
                cell_blocked[it.pos_y * MAX_COLUMNS + it.pos_x] = it.blocked;
            end
            KIND_SEARCH: begin
                r.found = astar_search(it.pos_x, it.pos_y, it.goal_x, it.goal_y, cost);
                r.path_cost = cost[COST_W-1:0];
                add_expected(r);
            end
            KIND_STEP: begin
                if (!path_ended) begin
                    idx = path_cursor % CELL_COUNT;
                    x = idx % MAX_COLUMNS;
                    y = idx / MAX_COLUMNS;
                    r.step_x = x[POS_W-1:0];
                    r.step_y = y[POS_W-1:0];
                    r.last = (idx == path_start);
                    if (r.last) begin
                        path_ended = 1;
                    end else begin
                        px = x - step_dx[cell_parent[idx]];
                        py = y - step_dy[cell_parent[idx]];
                        if (px < 0 || py < 0 || px >= MAX_COLUMNS || py >= MAX_ROWS)
                            path_ended = 1;
                        else
                            path_cursor = py * MAX_COLUMNS + px;
                    end
                    add_expected(r);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_in_item make_item(input logic [1:0] kind, input int px, input int py,
                                           input bit blk, input int gx, input int gy);
        t_in_item it;
        it.kind = kind;
        it.pos_x = px[POS_W-1:0];
        it.pos_y = py[POS_W-1:0];
        it.blocked = blk;
        it.goal_x = gx[POS_W-1:0];
        it.goal_y = gy[POS_W-1:0];
        return it;
    endfunction

    // Sender: one transaction per handshake, with random idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) plan_item(in_ch.data);
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (items_to_send.size() > 0) begin
                    if (!no_idling && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(1, 5) - 1;
                        in_ch.valid <= 1'b0;
                    end else begin
                        in_ch.valid <= 1'b1;
                        in_ch.data <= items_to_send.pop_front();
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: compares each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            take_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $realtime, out_ch.data);
                    error_count++;
                end else begin
                    want = results_due.pop_front();
                    if (out_ch.data.found !== want.found || out_ch.data.path_cost !== want.path_cost
                        || out_ch.data.step_x !== want.step_x
                        || out_ch.data.step_y !== want.step_y
                        || out_ch.data.last !== want.last) begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $realtime, want, out_ch.data);
                        error_count++;
                    end
                end
            end
            if (take_gap > 0) begin
                take_gap--;
                out_ch.ready <= 1'b0;
            end else if (!no_idling && $urandom_range(0, 7) == 0) begin
                take_gap = $urandom_range(1, 5) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Waits until every queued transaction is sent and every result has come back.
    task automatic wait_drained();
        while (items_to_send.size() > 0 || in_ch.valid || results_due.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input int v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v[DIM_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WIDTH) grid_cols = v & 127;
        else grid_rows = v & 127;
    endtask

    // Random traffic: mostly load, search and trace sequences inside the grid, plus noise.
    task automatic queue_random(input int count);
        int n;
        int w;
        int h;
        n = 0;
        w = fit_dim(grid_cols, MAX_COLUMNS);
        h = fit_dim(grid_rows, MAX_ROWS);
        while (n < count) begin
            if ($urandom_range(0, 9) < 7) begin
                repeat ($urandom_range(0, 3)) begin
                    add_item(make_item(KIND_LOAD, $urandom_range(0, w - 1),
                        $urandom_range(0, h - 1), $urandom_range(0, 2) == 0, $urandom, $urandom));
                    n++;
                end
                if ($urandom_range(0, 3) != 0)
                    add_item(make_item(KIND_SEARCH, $urandom_range(0, w - 1),
                        $urandom_range(0, h - 1), $urandom, $urandom_range(0, w - 1),
                        $urandom_range(0, h - 1)));
                else
                    add_item(make_item(KIND_SEARCH, $urandom_range(0, 63),
                        $urandom_range(0, 63), $urandom, $urandom_range(0, 63),
                        $urandom_range(0, 63)));
                n++;
                repeat ($urandom_range(1, 10)) begin
                    add_item(make_item(KIND_STEP, $urandom, $urandom, $urandom,
                        $urandom, $urandom));
                    n++;
                end
            end else begin
                add_item(make_item(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                    $urandom_range(0, 63), $urandom, $urandom_range(0, 63),
                    $urandom_range(0, 63)));
                n++;
            end
        end
    endtask

    // Main sequence: reset, directed cases, then random phases under several grid sizes.
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        no_idling = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full grid after reset: short searches near the corners, extremes of the fields.
        add_item(make_item(KIND_STEP, 0, 0, 0, 0, 0));
        add_item(make_item(KIND_LOAD, 63, 63, 1, 63, 63));
        add_item(make_item(KIND_LOAD, 63, 63, 0, 0, 0));
        add_item(make_item(KIND_LOAD, 62, 62, 1, 0, 0));
        add_item(make_item(KIND_SEARCH, 63, 63, 0, 60, 61));
        repeat (6) add_item(make_item(KIND_STEP, 0, 0, 0, 0, 0));
        add_item(make_item(KIND_SEARCH, 0, 0, 1, 0, 0));
        add_item(make_item(2'd3, 63, 63, 1, 63, 63));
        add_item(make_item(KIND_STEP, 63, 63, 1, 63, 63));
        add_item(make_item(KIND_STEP, 0, 0, 0, 0, 0));
        wait_drained();

        // Width zero acts as one, height above the maximum acts as the maximum.
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 127);
        add_item(make_item(KIND_SEARCH, 0, 0, 0, 0, 63));
        add_item(make_item(KIND_SEARCH, 5, 0, 0, 0, 3));
        add_item(make_item(KIND_STEP, 0, 0, 0, 0, 0));
        wait_drained();

        // Small grid: blocked start, blocked goal, goal outside the grid.
        write_reg(REG_WIDTH, 5);
        write_reg(REG_HEIGHT, 4);
        add_item(make_item(KIND_LOAD, 1, 1, 1, 0, 0));
        add_item(make_item(KIND_LOAD, 4, 3, 1, 0, 0));
        add_item(make_item(KIND_SEARCH, 1, 1, 0, 3, 2));
        repeat (4) add_item(make_item(KIND_STEP, 0, 0, 0, 0, 0));
        add_item(make_item(KIND_SEARCH, 0, 0, 0, 4, 3));
        add_item(make_item(KIND_SEARCH, 0, 0, 0, 9, 1));
        add_item(make_item(KIND_STEP, 0, 0, 0, 0, 0));
        add_item(make_item(KIND_LOAD, 1, 1, 0, 0, 0));
        add_item(make_item(KIND_LOAD, 4, 3, 0, 0, 0));
        wait_drained();

        // Random phases on small grids; the last one runs without idling.
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_WIDTH, $urandom_range(1, 8));
            write_reg(REG_HEIGHT, $urandom_range(1, 8));
            if (p == 3) no_idling = 1;
            queue_random(20);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #60ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
